/* hdl/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg
// shared types, field layout and constants of the rtp sequence stamper
// ----------------------------------------------------------------------------
package rss_pkg;

  // field widths
  localparam int SID_W  = 32;
  localparam int PT_W   = 7;
  localparam int LEN_W  = 16;
  localparam int TS_W   = 32;
  localparam int MS_W   = 48;
  localparam int SEQ_W  = 16;
  localparam int CFG_W  = 32;
  localparam int ADDR_W = 2;

  // rtp clock ticks per millisecond of wall clock
  localparam logic [TS_W-1:0] TICKS_PER_MS = 32'd90;

  // input tdata layout, lowest bit first
  localparam int IN_SID_LO  = 0;
  localparam int IN_HPT_LO  = IN_SID_LO + SID_W;
  localparam int IN_RPT_LO  = IN_HPT_LO + PT_W;
  localparam int IN_LEN_LO  = IN_RPT_LO + PT_W;
  localparam int IN_TS_LO   = IN_LEN_LO + LEN_W;
  localparam int IN_CAP_LO  = IN_TS_LO + TS_W;
  localparam int IN_NOW_LO  = IN_CAP_LO + MS_W;
  localparam int IN_USED_W  = IN_NOW_LO + MS_W;
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // input tuser layout
  localparam int IN_USER_PAD = 0;
  localparam int IN_USER_RED = 1;
  localparam int IN_USER_W   = 2;

  // output tdata layout, lowest bit first
  localparam int OUT_SEQ_LO  = 0;
  localparam int OUT_TS_LO   = OUT_SEQ_LO + SEQ_W;
  localparam int OUT_CAP_LO  = OUT_TS_LO + TS_W;
  localparam int OUT_PT_LO   = OUT_CAP_LO + MS_W;
  localparam int OUT_USED_W  = OUT_PT_LO + PT_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // queue between classifier and finisher
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [ADDR_W-1:0] {
    CFG_MEDIA_ID    = 2'd0,
    CFG_RTX_ID      = 2'd1,
    CFG_NEED_MARKER = 2'd2
  } cfg_idx_t;

  // classified packet handed from the front to the back
  typedef struct packed {
    logic             accepted;
    logic             extrap;     // empty rtx padding, advance timestamp
    logic             cap_adv;    // also advance capture time
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  ts;
    logic [MS_W-1:0]  cap;
    logic [PT_W-1:0]  pt;
    logic [MS_W-1:0]  elapsed;
  } job_t;

  // queue status towards its neighbours
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* hdl/rtp_sequence_stamper_top.sv */
// ----------------------------------------------------------------------------
// rtp_sequence_stamper_top
// rtp packet sequencer for one media stream and its rtx stream
// ----------------------------------------------------------------------------
// One result per packet descriptor, one descriptor per cycle sustained while
// the queue is not full. The front stage classifies each packet by ssrc and
// updates sequence counters and the saved media fields in the cycle the
// transaction is taken; a four entry queue then feeds the back stage, which
// applies the 90 tick per ms extrapolation for empty rtx padding and loads
// the output register. Input ready drops only while the queue is full, so a
// stalled output holds up to four packets in the queue plus one in the output
// register. Configuration must be written while the block is idle; the block
// itself does not enforce this.
module rtp_sequence_stamper_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [rss_pkg::ADDR_W-1:0]     cfg_addr,
  input  logic [rss_pkg::CFG_W-1:0]      cfg_wdata,
  // packet descriptor stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // fields from lsb: stream_id, header_payload_type, red_first_byte,
  // payload_length, rtp_time_in, capture_ms_in, now_ms, zero fill
  input  logic [rss_pkg::IN_DATA_W-1:0]  in_tdata,
  // fields from lsb: is_padding, is_redundant
  input  logic [rss_pkg::IN_USER_W-1:0]  in_tuser,
  // rtp marker bit
  input  logic                           in_tlast,
  // stamped packet stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // fields from lsb: sequence_number, rtp_time_out, capture_ms_out,
  // payload_type_out, zero fill
  output logic [rss_pkg::OUT_DATA_W-1:0] out_tdata,
  // fields from lsb: accepted
  output logic                           out_tuser
);
  import rss_pkg::*;

  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;
  logic    job_push;
  logic    job_pop;

  // classifier
  rss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .job_push  (job_push),
    .job       (push_job)
  );

  // job queue
  rss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // finisher and output register
  rss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .q_stat     (q_stat),
    .pop        (job_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* hdl/rss_front.sv */
// ----------------------------------------------------------------------------
// rss_front
// accepts packet descriptors, classifies them and keeps per-stream state
// ----------------------------------------------------------------------------
module rss_front (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [rss_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [rss_pkg::CFG_W-1:0]     cfg_wdata,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // fields from lsb: stream_id, header_payload_type, red_first_byte,
  // payload_length, rtp_time_in, capture_ms_in, now_ms, zero fill
  input  logic [rss_pkg::IN_DATA_W-1:0] in_tdata,
  // fields from lsb: is_padding, is_redundant
  input  logic [rss_pkg::IN_USER_W-1:0] in_tuser,
  input  logic                          in_tlast,
  // queue side
  input  rss_pkg::q_stat_t              q_stat,
  output logic                          job_push,
  output rss_pkg::job_t                 job
);
  import rss_pkg::*;

  // configuration registers
  logic [SID_W-1:0] media_id_r;
  logic [SID_W-1:0] rtx_id_r;
  logic             need_marker_r;

  // stream state
  logic [SEQ_W-1:0] media_cnt_r,  media_cnt_nxt;
  logic [SEQ_W-1:0] rtx_cnt_r,    rtx_cnt_nxt;
  logic [PT_W-1:0]  saved_pt_r;
  logic             saved_pt_vld_r;
  logic [TS_W-1:0]  saved_ts_r;
  logic [MS_W-1:0]  saved_cap_r;
  logic [MS_W-1:0]  saved_wc_r;
  logic             saved_marker_r;

  // unpacked fields
  logic [SID_W-1:0] sid;
  logic [PT_W-1:0]  hpt;
  logic [PT_W-1:0]  rpt;
  logic [LEN_W-1:0] plen;
  logic [TS_W-1:0]  ts_in;
  logic [MS_W-1:0]  cap_in;
  logic [MS_W-1:0]  now;
  logic             pad;
  logic             red;

  logic is_media;
  logic is_rtx;
  logic pad_ok;
  logic accept;
  logic use_saved;
  logic empty_rtx_pad;
  logic save_media;

  assign sid    = in_tdata[IN_SID_LO +: SID_W];
  assign hpt    = in_tdata[IN_HPT_LO +: PT_W];
  assign rpt    = in_tdata[IN_RPT_LO +: PT_W];
  assign plen   = in_tdata[IN_LEN_LO +: LEN_W];
  assign ts_in  = in_tdata[IN_TS_LO  +: TS_W];
  assign cap_in = in_tdata[IN_CAP_LO +: MS_W];
  assign now    = in_tdata[IN_NOW_LO +: MS_W];
  assign pad    = in_tuser[IN_USER_PAD];
  assign red    = in_tuser[IN_USER_RED];

  assign in_tready = !q_stat.full;
  assign job_push  = in_tvalid && in_tready;

  // classification, media wins when both ids match
  assign is_media      = (sid == media_id_r);
  assign is_rtx        = !is_media && (sid == rtx_id_r);
  assign pad_ok        = saved_pt_vld_r && !(need_marker_r && !saved_marker_r);
  assign accept        = is_media ? (!pad || pad_ok) : is_rtx;
  assign empty_rtx_pad = is_rtx && pad && (plen == '0);
  assign use_saved     = pad && (is_media || (plen == '0));
  assign save_media    = job_push && is_media && !pad;

  // job build, rejected packets carry all zeros
  always_comb begin
    job = '0;
    if (accept) begin
      job.accepted = 1'b1;
      job.seq      = is_media ? media_cnt_r : rtx_cnt_r;
      job.ts       = use_saved ? saved_ts_r  : ts_in;
      job.cap      = use_saved ? saved_cap_r : cap_in;
      job.pt       = (pad && is_media) ? saved_pt_r : hpt;
      job.extrap   = empty_rtx_pad && (saved_wc_r != '0);
      job.cap_adv  = empty_rtx_pad && (saved_wc_r != '0) && (saved_cap_r != '0);
      job.elapsed  = now - saved_wc_r;
    end
  end

  // counter next values
  always_comb begin
    media_cnt_nxt = media_cnt_r;
    rtx_cnt_nxt   = rtx_cnt_r;
    if (job_push && accept) begin
      if (is_media) begin
        media_cnt_nxt = media_cnt_r + 1'b1;
      end else begin
        rtx_cnt_nxt = rtx_cnt_r + 1'b1;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      media_id_r    <= '0;
      rtx_id_r      <= '0;
      need_marker_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_MEDIA_ID:    media_id_r    <= cfg_wdata;
        CFG_RTX_ID:      rtx_id_r      <= cfg_wdata;
        CFG_NEED_MARKER: need_marker_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stream state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      media_cnt_r    <= '0;
      rtx_cnt_r      <= '0;
      saved_pt_r     <= '0;
      saved_pt_vld_r <= 1'b0;
      saved_ts_r     <= '0;
      saved_cap_r    <= '0;
      saved_wc_r     <= '0;
      saved_marker_r <= 1'b0;
    end else begin
      media_cnt_r <= media_cnt_nxt;
      rtx_cnt_r   <= rtx_cnt_nxt;
      if (save_media) begin
        saved_marker_r <= in_tlast;
        saved_pt_r     <= red ? rpt : hpt;
        saved_pt_vld_r <= 1'b1;
        saved_ts_r     <= ts_in;
        saved_cap_r    <= cap_in;
        saved_wc_r     <= now;
      end
    end
  end

  // rejected jobs never carry a sequence number
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    job_push && !job.accepted |-> job.seq == '0 && !job.extrap)
    else $error("rejected job carries data");

  // media counter advances only on accepted media
  a_media_step: assert property (@(posedge clk) disable iff (!rst_n)
    job_push && accept && is_media |=> media_cnt_r == $past(media_cnt_r) + 1'b1)
    else $error("media counter did not advance");

  // padding never stores state
  a_pad_no_save: assert property (@(posedge clk) disable iff (!rst_n)
    job_push && pad |=> $stable(saved_wc_r) && $stable(saved_pt_r))
    else $error("padding changed saved state");

endmodule

/* hdl/rss_queue.sv */
// ----------------------------------------------------------------------------
// rss_queue
// short job queue between classifier and finisher
// ----------------------------------------------------------------------------
module rss_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rss_pkg::job_t    push_job,
  input  logic             pop,
  output rss_pkg::job_t    head_job,
  output rss_pkg::q_stat_t q_stat
);
  import rss_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r,    cnt_nxt;

  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_job     = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.full |-> cnt_r[QPTR_W-1:0] == QPTR_W'(wr_ptr_r - rd_ptr_r))
    else $error("fill count out of step with pointers");

endmodule

/* hdl/rss_back.sv */
// ----------------------------------------------------------------------------
// rss_back
// finishes timestamp extrapolation and holds the output register
// ----------------------------------------------------------------------------
module rss_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rss_pkg::job_t                  head_job,
  input  rss_pkg::q_stat_t               q_stat,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // fields from lsb: sequence_number, rtp_time_out, capture_ms_out,
  // payload_type_out, zero fill
  output logic [rss_pkg::OUT_DATA_W-1:0] out_tdata,
  // fields from lsb: accepted
  output logic                           out_tuser
);
  import rss_pkg::*;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r;
  logic [TS_W-1:0]       ts_fin;
  logic [MS_W-1:0]       cap_fin;
  logic [TS_W-1:0]       ticks;

  assign pop        = !q_stat.empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // elapsed time in rtp ticks, modulo 2^32
  assign ticks   = TS_W'(head_job.elapsed[TS_W-1:0] * TICKS_PER_MS);
  assign ts_fin  = head_job.extrap  ? head_job.ts + ticks : head_job.ts;
  assign cap_fin = head_job.cap_adv ? head_job.cap + head_job.elapsed : head_job.cap;

  // result packing
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[OUT_SEQ_LO +: SEQ_W] = head_job.seq;
    out_data_nxt[OUT_TS_LO  +: TS_W]  = ts_fin;
    out_data_nxt[OUT_CAP_LO +: MS_W]  = cap_fin;
    out_data_nxt[OUT_PT_LO  +: PT_W]  = head_job.pt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
      out_user_r <= head_job.accepted;
    end
  end

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("popped job lost");

  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_user_r |-> out_data_r == '0)
    else $error("rejected result not cleared");

  a_no_extrap_reject: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_job.cap_adv |-> head_job.extrap && head_job.accepted)
    else $error("capture advance without extrapolation");

endmodule
